// ===== src/scs1a_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs1a_pkg - shared types and constants for the set-1 scancode translator
// Scancode values, the decoder-to-keymap request struct and the two
// keymap tables (plain and shifted) as constant functions.
// ----------------------------------------------------------------------------
package scs1a_pkg;

	// Scancode values
	localparam logic [7:0] SC_PREFIX  = 8'hE0;
	localparam logic [7:0] SC_LSHIFT  = 8'h2A;
	localparam logic [7:0] SC_RSHIFT  = 8'h36;
	localparam logic [7:0] SC_CTRL    = 8'h1D;
	localparam logic [7:0] SC_C_KEY   = 8'h2E;
	localparam logic [7:0] SC_CAPS    = 8'h3A;
	localparam logic [7:0] BREAK_MASK = 8'h80;

	// Event kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_IRQ  = 1'b1;

	// ASCII letter bounds and case bit
	localparam logic [6:0] ASCII_LC_A  = 7'h61;
	localparam logic [6:0] ASCII_LC_Z  = 7'h7A;
	localparam logic [6:0] ASCII_CASE  = 7'h20;
	localparam logic [6:0] ASCII_NONE  = 7'h00;

	// Request from the decoder to the keymap stage
	typedef struct packed {
		logic lookup;   // make code to translate
		logic irq;      // ctrl plus C
		logic shift;    // shift held
		logic caps;     // caps lock on
	} key_req_t;

	// Unshifted keymap, zero where no key is mapped
	function automatic logic [6:0] map_plain(input logic [6:0] code);
		logic [6:0] ch;
		unique case (code)
			7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;
			7'h05: ch = 7'h34;  7'h06: ch = 7'h35;  7'h07: ch = 7'h36;
			7'h08: ch = 7'h37;  7'h09: ch = 7'h38;  7'h0A: ch = 7'h39;
			7'h0B: ch = 7'h30;  7'h0C: ch = 7'h2D;  7'h0D: ch = 7'h3D;
			7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;
			7'h10: ch = 7'h71;  7'h11: ch = 7'h77;  7'h12: ch = 7'h65;
			7'h13: ch = 7'h72;  7'h14: ch = 7'h74;  7'h15: ch = 7'h79;
			7'h16: ch = 7'h75;  7'h17: ch = 7'h69;  7'h18: ch = 7'h6F;
			7'h19: ch = 7'h70;  7'h1A: ch = 7'h5B;  7'h1B: ch = 7'h5D;
			7'h1C: ch = 7'h0A;
			7'h1E: ch = 7'h61;  7'h1F: ch = 7'h73;  7'h20: ch = 7'h64;
			7'h21: ch = 7'h66;  7'h22: ch = 7'h67;  7'h23: ch = 7'h68;
			7'h24: ch = 7'h6A;  7'h25: ch = 7'h6B;  7'h26: ch = 7'h6C;
			7'h27: ch = 7'h3B;  7'h28: ch = 7'h27;  7'h29: ch = 7'h60;
			7'h2B: ch = 7'h5C;  7'h2C: ch = 7'h7A;  7'h2D: ch = 7'h78;
			7'h2E: ch = 7'h63;  7'h2F: ch = 7'h76;  7'h30: ch = 7'h62;
			7'h31: ch = 7'h6E;  7'h32: ch = 7'h6D;  7'h33: ch = 7'h2C;
			7'h34: ch = 7'h2E;  7'h35: ch = 7'h2F;  7'h39: ch = 7'h20;
			default: ch = ASCII_NONE;
		endcase
		return ch;
	endfunction

	// Shifted keymap, zero where no key is mapped
	function automatic logic [6:0] map_shifted(input logic [6:0] code);
		logic [6:0] ch;
		unique case (code)
			7'h02: ch = 7'h21;  7'h03: ch = 7'h40;  7'h04: ch = 7'h23;
			7'h05: ch = 7'h24;  7'h06: ch = 7'h25;  7'h07: ch = 7'h5E;
			7'h08: ch = 7'h26;  7'h09: ch = 7'h2A;  7'h0A: ch = 7'h28;
			7'h0B: ch = 7'h29;  7'h0C: ch = 7'h5F;  7'h0D: ch = 7'h2B;
			7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;
			7'h10: ch = 7'h51;  7'h11: ch = 7'h57;  7'h12: ch = 7'h45;
			7'h13: ch = 7'h52;  7'h14: ch = 7'h54;  7'h15: ch = 7'h59;
			7'h16: ch = 7'h55;  7'h17: ch = 7'h49;  7'h18: ch = 7'h4F;
			7'h19: ch = 7'h50;  7'h1A: ch = 7'h7B;  7'h1B: ch = 7'h7D;
			7'h1C: ch = 7'h0A;
			7'h1E: ch = 7'h41;  7'h1F: ch = 7'h53;  7'h20: ch = 7'h44;
			7'h21: ch = 7'h46;  7'h22: ch = 7'h47;  7'h23: ch = 7'h48;
			7'h24: ch = 7'h4A;  7'h25: ch = 7'h4B;  7'h26: ch = 7'h4C;
			7'h27: ch = 7'h3A;  7'h28: ch = 7'h22;  7'h29: ch = 7'h7E;
			7'h2B: ch = 7'h7C;  7'h2C: ch = 7'h5A;  7'h2D: ch = 7'h58;
			7'h2E: ch = 7'h43;  7'h2F: ch = 7'h56;  7'h30: ch = 7'h42;
			7'h31: ch = 7'h4E;  7'h32: ch = 7'h4D;  7'h33: ch = 7'h3C;
			7'h34: ch = 7'h3E;  7'h35: ch = 7'h3F;  7'h39: ch = 7'h20;
			default: ch = ASCII_NONE;
		endcase
		return ch;
	endfunction

endpackage

// ===== src/scancode_set1_to_ascii.sv =====
`timescale 1ns / 1ps
// An accepted scancode item goes through the input register and then the result
// register; an output stall can hold it in the input register in between.
// Throughput: one scancode item per clock while in_stall is low; with the output stalled the input
// register still takes one more item before in_stall rises.
// Reset clears the modifier flags and both valid bits; items that produce no
// result only update the flags.
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii - PS/2 set-1 scancode to ASCII translator
// Input register, flag update and keymap lookup, then a result register.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] scan_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       event_kind,
	output logic [6:0] char_code
);
	import scs1a_pkg::*;

	logic       valid_s1;
	logic [7:0] code_s1;
	logic       valid_s2;
	logic       kind_s2;
	logic [6:0] char_s2;

	logic       s2_free, fire;
	logic       emit, kind;
	logic [6:0] char_val;
	key_req_t   req;

	// pipeline flow
	assign s2_free  = ~valid_s2 | ~out_stall;
	assign fire     = valid_s1 & s2_free;
	assign in_stall = valid_s1 & ~s2_free;

	scs1a_keystate u_keystate (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.scan_code (code_s1),
		.req       (req)
	);

	scs1a_keymap u_keymap (
		.code     (code_s1[6:0]),
		.req      (req),
		.emit     (emit),
		.kind     (kind),
		.char_out (char_val)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			code_s1 <= scan_code;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= fire & emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_s2 <= kind;
			char_s2 <= char_val;
		end
	end

	assign out_valid  = valid_s2;
	assign event_kind = kind_s2;
	assign char_code  = char_s2;

endmodule

// ===== src/scs1a_keystate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs1a_keystate - modifier flags and scancode classification
// Holds shift, caps lock, ctrl and the extended-prefix flag, updates them
// when an item is processed, and tells the keymap what to do with the byte.
// ----------------------------------------------------------------------------
module scs1a_keystate (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           scan_code,
	output scs1a_pkg::key_req_t  req
);
	import scs1a_pkg::*;

	logic shift_q, caps_q, ctrl_q, prefix_q;
	logic shift_d, caps_d, ctrl_d, prefix_d;
	logic lookup, irq;

	// classify the byte against the current flags
	always_comb begin
		shift_d  = shift_q;
		caps_d   = caps_q;
		ctrl_d   = ctrl_q;
		prefix_d = prefix_q;
		lookup   = 1'b0;
		irq      = 1'b0;
		priority if (scan_code == SC_PREFIX) begin
			prefix_d = 1'b1;
		end else if (prefix_q) begin
			// byte after the prefix: only right ctrl counts
			prefix_d = 1'b0;
			if (scan_code == SC_CTRL) begin
				ctrl_d = 1'b1;
			end else if (scan_code == (SC_CTRL | BREAK_MASK)) begin
				ctrl_d = 1'b0;
			end
		end else if (scan_code == SC_LSHIFT || scan_code == SC_RSHIFT) begin
			shift_d = 1'b1;
		end else if (scan_code == (SC_LSHIFT | BREAK_MASK) ||
				scan_code == (SC_RSHIFT | BREAK_MASK)) begin
			shift_d = 1'b0;
		end else if (scan_code == SC_CTRL) begin
			ctrl_d = 1'b1;
		end else if (scan_code == (SC_CTRL | BREAK_MASK)) begin
			ctrl_d = 1'b0;
		end else if (scan_code == SC_CAPS) begin
			caps_d = ~caps_q;
		end else if ((scan_code & BREAK_MASK) != 8'h00) begin
			// other releases are ignored
		end else if (ctrl_q && scan_code == SC_C_KEY) begin
			irq = 1'b1;
		end else begin
			lookup = 1'b1;
		end
	end

	assign req = '{lookup: lookup, irq: irq, shift: shift_q, caps: caps_q};

	// flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 1'b0;
			caps_q   <= 1'b0;
			ctrl_q   <= 1'b0;
			prefix_q <= 1'b0;
		end else if (fire) begin
			shift_q  <= shift_d;
			caps_q   <= caps_d;
			ctrl_q   <= ctrl_d;
			prefix_q <= prefix_d;
		end
	end

endmodule

// ===== src/scs1a_keymap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs1a_keymap - keymap lookup and result forming
// Picks the plain or shifted table, applies caps lock to lowercase
// letters and decides whether the item yields a result.
// ----------------------------------------------------------------------------
module scs1a_keymap (
	input  logic                 [6:0] code,
	input  scs1a_pkg::key_req_t        req,
	output logic                       emit,
	output logic                       kind,
	output logic                 [6:0] char_out
);
	import scs1a_pkg::*;

	logic [6:0] ch;
	logic       is_lower;

	// table lookup
	assign ch       = req.shift ? map_shifted(code) : map_plain(code);
	assign is_lower = (ch >= ASCII_LC_A) && (ch <= ASCII_LC_Z);

	// result: interrupt, mapped character, or nothing
	always_comb begin
		emit     = 1'b0;
		kind     = KIND_CHAR;
		char_out = ASCII_NONE;
		if (req.irq) begin
			emit = 1'b1;
			kind = KIND_IRQ;
		end else if (req.lookup && ch != ASCII_NONE) begin
			emit     = 1'b1;
			char_out = (req.caps && is_lower) ? (ch & ~ASCII_CASE) : ch;
		end
	end

endmodule
